[rtl/hbtm_pkg.sv]
// Shared types and constants for the height blend texture mixer.
// Used by hbtm_geom and height_blend_texture_mixer; depends on nothing.
package hbtm_pkg;

    // Fixed field widths
    localparam int SPAN_W     = 16;
    localparam int MIX_W      = 7;
    localparam int LCNT_W     = 3;
    localparam int HEIGHT_W   = 16;
    localparam int TEX_W      = 8;
    localparam int TEX_LAYERS = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [SPAN_W-1:0] SPAN_RST = 16'd1024;
    localparam logic [MIX_W-1:0]  MIX_RST  = 7'd51;
    localparam logic [LCNT_W-1:0] LCNT_RST = 3'd4;

    // Band geometry: Q16.8 positions, band and ramp widths
    localparam int GW    = 32;
    localparam int DW    = 24;
    // Divisor 256*n - (n-1)*mix for up to eight layers
    localparam int DVW   = 12;
    // Numerator span*65536 and its bit count
    localparam int NUM_W = SPAN_W + 16;
    localparam int CNT_W = 5;

    // Ramp weight in Q0.8, produced two bits per division stage
    localparam int WB    = 8;
    localparam int SPS   = 2;
    localparam int NDIV  = WB / SPS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT_SPAN  = 2'd0,
        CFG_MIX_FRACTION = 2'd1,
        CFG_LAYER_COUNT  = 2'd2
    } cfg_idx_t;

    // One layer's band: outer edges, inner edges of the core, in use
    typedef struct packed {
        logic signed [GW-1:0] lo;
        logic signed [GW-1:0] hi;
        logic signed [GW-1:0] lm;
        logic signed [GW-1:0] rm;
        logic                 active;
    } geom_t;

endpackage

[rtl/hbtm_geom.sv]
// Configuration registers and band geometry unit of the texture mixer.
// Depends on hbtm_pkg; recomputes every layer band after reset and after each write.
module hbtm_geom
    import hbtm_pkg::*;
#(
    parameter int MAX_LAYERS = 4,
    parameter int LANES      = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output geom_t [LANES-1:0]     geom,
    output logic [DW-1:0]         ramp_w,
    output logic                  busy
);

    localparam int NW  = $clog2(MAX_LAYERS + 1);
    localparam int LIW = (LANES > 1) ? $clog2(LANES) : 1;

    typedef enum logic [2:0] {G_START, G_DIV, G_MULT, G_LAYER, G_DONE} gstate_t;

    gstate_t               state_reg, state_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [MIX_W-1:0]      mix_reg, mix_next;
    logic [LCNT_W-1:0]     lcnt_reg, lcnt_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [DVW-1:0]        dvs_reg, dvs_next;
    logic [DVW-1:0]        rem_reg, rem_next;
    logic [SPAN_W-1:0]     num_reg, num_next;
    logic [DW-1:0]         quo_reg, quo_next;
    logic [DW-1:0]         m_reg, m_next;
    logic signed [GW-1:0]  acc_reg, acc_next;
    logic [LIW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    geom_t [LANES-1:0]     geom_reg, geom_next;

    logic [SPAN_W-1:0]        span_eff;
    logic [NW-1:0]            n_clamp;
    logic [DVW-1:0]           n_wide;
    logic [DVW:0]             div_t;
    logic                     div_ge;
    logic [MIX_W+DW-1:0]      mix_prod;
    logic signed [GW-1:0]     band_hi;
    logic                     cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom      = geom_reg;
    assign ramp_w    = m_reg;
    assign busy      = (state_reg != G_DONE);

    // Zero span behaves as one; clamp the layer count into 1..MAX_LAYERS
    assign span_eff = (span_reg == '0) ? SPAN_W'(1) : span_reg;

    always_comb begin
        if (lcnt_reg == '0) begin
            n_clamp = NW'(1);
        end else if (32'(lcnt_reg) > MAX_LAYERS) begin
            n_clamp = NW'(MAX_LAYERS);
        end else begin
            n_clamp = NW'(lcnt_reg);
        end
    end

    assign n_wide   = DVW'(n_clamp);
    assign div_t    = {rem_reg, num_reg[SPAN_W-1]};
    assign div_ge   = (div_t >= {1'b0, dvs_reg});
    assign mix_prod = mix_reg * quo_reg;
    assign band_hi  = acc_reg + $signed(GW'(quo_reg));

    always_comb begin
        state_next = state_reg;
        span_next  = span_reg;
        mix_next   = mix_reg;
        lcnt_next  = lcnt_reg;
        n_next     = n_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        m_next     = m_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        geom_next  = geom_reg;

        unique case (state_reg)
            // Latch layer count and divisor, load the span as numerator
            G_START: begin
                n_next     = n_clamp;
                dvs_next   = (n_wide << 8) - (n_wide - DVW'(1)) * DVW'(mix_reg);
                rem_next   = '0;
                num_next   = span_eff;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = G_DIV;
            end
            // Band width: one restoring quotient bit per cycle
            G_DIV: begin
                rem_next = div_ge ? DVW'(div_t - {1'b0, dvs_reg}) : DVW'(div_t);
                quo_next = {quo_reg[DW-2:0], div_ge};
                num_next = {num_reg[SPAN_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = G_MULT;
                end
            end
            // Overlap width and the lower edge of the first band
            G_MULT: begin
                m_next     = DW'(mix_prod >> 8);
                acc_next   = -$signed(GW'({span_eff, 7'd0}));
                idx_next   = '0;
                state_next = G_LAYER;
            end
            // Lay out one band per cycle, stepping by width minus overlap
            G_LAYER: begin
                geom_next[idx_reg].lo     = acc_reg;
                geom_next[idx_reg].hi     = band_hi;
                geom_next[idx_reg].lm     = (idx_reg == '0) ? acc_reg
                                          : acc_reg + $signed(GW'(m_reg));
                geom_next[idx_reg].rm     = (int'(idx_reg) == int'(n_reg) - 1) ? band_hi
                                          : band_hi - $signed(GW'(m_reg));
                geom_next[idx_reg].active = (int'(idx_reg) < int'(n_reg));
                acc_next = acc_reg + $signed(GW'(quo_reg)) - $signed(GW'(m_reg));
                idx_next = idx_reg + LIW'(1);
                if (idx_reg == LIW'(LANES - 1)) begin
                    state_next = G_DONE;
                end
            end
            G_DONE: begin
            end
        endcase

        // Register writes; any write restarts the band layout
        if (cfg_wr) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HEIGHT_SPAN:  span_next = cfg_data[SPAN_W-1:0];
                CFG_MIX_FRACTION: mix_next  = cfg_data[MIX_W-1:0];
                CFG_LAYER_COUNT:  lcnt_next = cfg_data[LCNT_W-1:0];
                default: begin
                end
            endcase
            state_next = G_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_START;
            span_reg  <= SPAN_RST;
            mix_reg   <= MIX_RST;
            lcnt_reg  <= LCNT_RST;
        end else begin
            state_reg <= state_next;
            span_reg  <= span_next;
            mix_reg   <= mix_next;
            lcnt_reg  <= lcnt_next;
        end
        n_reg    <= n_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        geom_reg <= geom_next;
    end

    // A register write always restarts the layout
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (state_reg == G_START))
        else $error("geometry not restarted after register write");

    // Overlap never exceeds the band width once laid out
    a_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> (m_reg <= quo_reg))
        else $error("overlap wider than band");

    // First band starts at minus half the span
    a_first_band: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> (geom_reg[0].lo == -$signed(GW'({span_eff, 7'd0}))))
        else $error("first band edge off center");

endmodule

[rtl/height_blend_texture_mixer.sv]
// Top level of the height blend texture mixer: pixel pipeline plus geometry unit.
// Depends on hbtm_pkg and hbtm_geom.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  pixel   | s_valid s_ready s_height_sample s_texel_* | in
//  result  | m_valid m_ready m_blended_byte          | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// One pixel per cycle when not stalled; stages: classify, four 2-bit ramp division
// stages, texel weighting, sum and saturate.
// After reset and after every register write the geometry unit lays out the bands
// through its start, bit-serial band width divider, overlap and per-lane states; s_ready
// stays low meanwhile. Reset is synchronous and clears valid bits and control.
// A stall on m_ready holds the result; upstream stages keep filling empty slots.
module height_blend_texture_mixer
    import hbtm_pkg::*;
#(
    parameter int MAX_LAYERS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [HEIGHT_W-1:0] s_height_sample,
    input  logic [TEX_W-1:0]           s_texel_layer0,
    input  logic [TEX_W-1:0]           s_texel_layer1,
    input  logic [TEX_W-1:0]           s_texel_layer2,
    input  logic [TEX_W-1:0]           s_texel_layer3,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [TEX_W-1:0]           m_blended_byte,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    // Layers past the texel fields always weigh nothing
    localparam int LANES = (MAX_LAYERS < TEX_LAYERS) ? MAX_LAYERS : TEX_LAYERS;
    localparam int NSTG  = NDIV + 3;
    localparam int SUM_W = TEX_W + $clog2(LANES + 1);

    typedef enum logic [1:0] {WM_ZERO, WM_FULL, WM_RAMP} wmode_t;

    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [WB-1:0]    quo;
        wmode_t           mode;
        logic [TEX_W-1:0] tex;
    } lane_t;

    geom_t [LANES-1:0]     geom_w;
    logic [DW-1:0]         ramp_w;
    logic                  geom_busy;

    logic                  valid_reg [NSTG];
    logic                  valid_next [NSTG];
    logic                  en [NSTG];
    lane_t                 lane_reg [NDIV+1][LANES];
    lane_t                 lane_next [NDIV+1][LANES];
    logic [TEX_W-1:0]      term_reg [LANES];
    logic [TEX_W-1:0]      term_next [LANES];
    logic [TEX_W-1:0]      out_reg, out_next;

    logic [TEX_W-1:0]      tex_in [TEX_LAYERS];
    logic signed [GW-1:0]  h_ext;
    logic [SUM_W-1:0]      sum;
    logic                  in_take;

    hbtm_geom #(
        .MAX_LAYERS (MAX_LAYERS),
        .LANES      (LANES)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom_w),
        .ramp_w    (ramp_w),
        .busy      (geom_busy)
    );

    // Two restoring quotient bits of x*256/M
    function automatic lane_t div_steps(input lane_t l, input logic [DW-1:0] m);
        logic [DW:0] t;
        lane_t       o;
        o = l;
        for (int k = 0; k < SPS; k++) begin
            t = {o.rem, 1'b0};
            if (t >= {1'b0, m}) begin
                o.rem = DW'(t - {1'b0, m});
                o.quo = {o.quo[WB-2:0], 1'b1};
            end else begin
                o.rem = DW'(t);
                o.quo = {o.quo[WB-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Advance a stage when it is empty or the next one moves
    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0] && !geom_busy;
    assign in_take = s_valid && s_ready;

    always_comb begin
        valid_next[0] = in_take;
        for (int k = 1; k < NSTG; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign tex_in[0] = s_texel_layer0;
    assign tex_in[1] = s_texel_layer1;
    assign tex_in[2] = s_texel_layer2;
    assign tex_in[3] = s_texel_layer3;

    // Height in Q16.8
    assign h_ext = $signed({{(GW-HEIGHT_W-8){s_height_sample[HEIGHT_W-1]}},
                            s_height_sample, 8'h00});

    // Classify each layer: outside, core, or on a ramp with its offset
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_next[0][i].tex  = tex_in[i];
            lane_next[0][i].quo  = '0;
            lane_next[0][i].rem  = '0;
            lane_next[0][i].mode = WM_FULL;
            if (!geom_w[i].active || h_ext < geom_w[i].lo || h_ext > geom_w[i].hi) begin
                lane_next[0][i].mode = WM_ZERO;
            end else if (h_ext < geom_w[i].lm) begin
                lane_next[0][i].mode = WM_RAMP;
                lane_next[0][i].rem  = DW'(h_ext - geom_w[i].lo);
            end else if (h_ext > geom_w[i].rm) begin
                lane_next[0][i].mode = WM_RAMP;
                lane_next[0][i].rem  = DW'(geom_w[i].hi - h_ext);
            end
        end
        // Ramp weight division stages
        for (int s = 1; s <= NDIV; s++) begin
            for (int i = 0; i < LANES; i++) begin
                lane_next[s][i] = div_steps(lane_reg[s-1][i], ramp_w);
            end
        end
    end

    // Weight each texel; keep the integer part
    always_comb begin
        logic [2*TEX_W-1:0] prod;
        prod = '0;
        for (int i = 0; i < LANES; i++) begin
            prod = lane_reg[NDIV][i].tex * TEX_W'(lane_reg[NDIV][i].quo);
            case (lane_reg[NDIV][i].mode)
                WM_FULL: term_next[i] = lane_reg[NDIV][i].tex;
                WM_RAMP: term_next[i] = prod[2*TEX_W-1:TEX_W];
                default: term_next[i] = '0;
            endcase
        end
    end

    // Sum the layers and saturate
    always_comb begin
        sum = '0;
        for (int i = 0; i < LANES; i++) begin
            sum = sum + SUM_W'(term_reg[i]);
        end
        out_next = (sum > SUM_W'(255)) ? TEX_W'(255) : sum[TEX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
        for (int s = 0; s <= NDIV; s++) begin
            if (en[s]) begin
                lane_reg[s] <= lane_next[s];
            end
        end
        if (en[NDIV+1]) begin
            term_reg <= term_next;
        end
        if (en[NDIV+2]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = valid_reg[NSTG-1];
    assign m_blended_byte = out_reg;

    for (genvar g = 0; g < LANES; g++) begin : g_chk
        // Remainder of a ramp division stays below the ramp width
        a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
            (valid_reg[NDIV] && lane_reg[NDIV][g].mode == WM_RAMP)
                |-> (lane_reg[NDIV][g].rem < ramp_w))
            else $error("ramp division remainder out of range");

        // A layer beyond the layer count never contributes
        a_inactive: assert property (@(posedge aclk) disable iff (!aresetn)
            (valid_reg[0] && !geom_w[g].active) |-> (lane_reg[0][g].mode == WM_ZERO))
            else $error("unused layer classified as contributing");
    end

endmodule

[tb/height_blend_texture_mixer_tb.sv]
// Self-checking testbench for height_blend_texture_mixer: a directed table, then random
// configuration phases, most under random source gaps and sink stalls, checked by a blend predictor.
// Depends on hbtm_pkg and the RTL of height_blend_texture_mixer.
module height_blend_texture_mixer_tb;
    import hbtm_pkg::*;

    localparam int LAYER_LIMIT   = 4;
    localparam int PIPE_LATENCY  = 7;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_WAIT      = 6;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIR_COUNT     = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // One pixel transaction plus the register values it runs under
    typedef struct packed {
        logic [CFG_DATA_W-1:0]      span;
        logic [CFG_DATA_W-1:0]      mix;
        logic [CFG_DATA_W-1:0]      lcnt;
        logic signed [HEIGHT_W-1:0] height;
        logic [TEX_W-1:0]           t0;
        logic [TEX_W-1:0]           t1;
        logic [TEX_W-1:0]           t2;
        logic [TEX_W-1:0]           t3;
        logic                       typed;
        logic [TEX_W-1:0]           result;
    } pixel_case_t;

    // span, mix, layers, height, texels 0..3, typed, result
    localparam pixel_case_t DIR_CASES [DIR_COUNT] = '{
        // reset geometry: far outside, layer cores, overlap zones
        '{1024, 51, 4, -32768, 255, 255, 255, 255, 1, 0},
        '{1024, 51, 4, 32767, 255, 255, 255, 255, 1, 0},
        '{1024, 51, 4, -400, 200, 255, 255, 255, 1, 200},
        '{1024, 51, 4, 0, 255, 255, 255, 255, 0, 0},
        '{1024, 51, 4, 0, 0, 0, 0, 0, 1, 0},
        '{1024, 51, 4, 400, 1, 2, 3, 77, 1, 77},
        '{1024, 51, 4, -512, 90, 80, 70, 60, 0, 0},
        '{1024, 51, 4, -300, 128, 64, 32, 16, 0, 0},
        // no overlap: ramps never entered, shared edges saturate
        '{1024, 0, 4, -256, 255, 255, 0, 0, 1, 255},
        '{1024, 0, 4, -255, 17, 34, 51, 68, 0, 0},
        '{1024, 0, 4, 256, 0, 0, 255, 255, 0, 0},
        // widest span, widest mix, single layer
        '{16'hFFFF, 16'hFFFF, 1, -32768, 255, 255, 255, 255, 1, 0},
        '{16'hFFFF, 16'hFFFF, 1, 32767, 99, 1, 2, 3, 1, 99},
        '{16'hFFFF, 16'hFFFF, 1, 0, 123, 200, 200, 200, 1, 123},
        // zero span and zero layer count fall back to one
        '{0, 100, 0, 0, 55, 9, 9, 9, 1, 55},
        '{0, 100, 0, 1, 55, 9, 9, 9, 1, 0},
        '{0, 100, 0, -1, 55, 9, 9, 9, 1, 0},
        // layer count above the limit, tiny span, maximum mix
        '{4, 127, 16'hFFFF, -2, 250, 130, 70, 10, 0, 0},
        '{4, 127, 16'hFFFF, -1, 250, 130, 70, 10, 0, 0},
        '{4, 127, 16'hFFFF, 0, 250, 130, 70, 10, 0, 0},
        '{4, 127, 16'hFFFF, 1, 250, 130, 70, 10, 0, 0},
        '{4, 127, 16'hFFFF, 2, 250, 130, 70, 10, 0, 0},
        // two and three layers
        '{1000, 64, 2, 0, 240, 180, 5, 5, 0, 0},
        '{300, 32, 3, -50, 11, 222, 133, 44, 0, 0},
        '{300, 32, 3, 50, 11, 222, 133, 44, 0, 0}
    };

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic signed [HEIGHT_W-1:0] s_height_sample = '0;
    logic [TEX_W-1:0]           s_texel_layer0  = '0;
    logic [TEX_W-1:0]           s_texel_layer1  = '0;
    logic [TEX_W-1:0]           s_texel_layer2  = '0;
    logic [TEX_W-1:0]           s_texel_layer3  = '0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic [TEX_W-1:0]           m_blended_byte;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index       = '0;
    logic [CFG_DATA_W-1:0]      cfg_data        = '0;

    // Typed expectation travelling with the pixel in flight on the input channel
    logic                       pix_typed       = 1'b0;
    logic [TEX_W-1:0]           pix_result      = '0;

    // Predictor copy of the registers, and register values last written by the sender
    logic [SPAN_W-1:0]          cfg_span_q;
    logic [MIX_W-1:0]           cfg_mix_q;
    logic [LCNT_W-1:0]          cfg_lcnt_q;
    logic [CFG_DATA_W-1:0]      cur_span        = CFG_DATA_W'(SPAN_RST);
    logic [CFG_DATA_W-1:0]      cur_mix         = CFG_DATA_W'(MIX_RST);
    logic [CFG_DATA_W-1:0]      cur_lcnt        = CFG_DATA_W'(LCNT_RST);

    logic [TEX_W-1:0]           blend_expected [$];
    int                         fault_count     = 0;
    int                         idle_cycles     = 0;
    bit                         moved;
    bit                         no_idle         = 1'b0;

    height_blend_texture_mixer #(
        .MAX_LAYERS(LAYER_LIMIT)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_height_sample (s_height_sample),
        .s_texel_layer0  (s_texel_layer0),
        .s_texel_layer1  (s_texel_layer1),
        .s_texel_layer2  (s_texel_layer2),
        .s_texel_layer3  (s_texel_layer3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blended_byte  (m_blended_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Weighted texel sum of one pixel under the current band layout
    function automatic logic [TEX_W-1:0] blend_predict(input logic signed [HEIGHT_W-1:0] hs,
                                                       input logic [TEX_W-1:0] t0,
                                                       input logic [TEX_W-1:0] t1,
                                                       input logic [TEX_W-1:0] t2,
                                                       input logic [TEX_W-1:0] t3);
        longint span, mf, n, d, w, m, h, sum, lo, hi, lm, rm, tex, wt;
        logic [TEX_W-1:0] texels [TEX_LAYERS];
        int i;
        texels[0] = t0;
        texels[1] = t1;
        texels[2] = t2;
        texels[3] = t3;
        span = (cfg_span_q == '0) ? 64'sd1 : longint'(cfg_span_q);
        mf   = longint'(cfg_mix_q);
        n    = longint'(cfg_lcnt_q);
        if (n < 1) n = 1;
        if (n > LAYER_LIMIT) n = LAYER_LIMIT;
        // Band width and overlap in Q16.8
        d   = 256 * n - (n - 1) * mf;
        w   = (span * 65536) / d;
        m   = (mf * w) / 256;
        h   = longint'(hs) * 256;
        sum = 0;
        for (i = 0; i < n; i++) begin
            lo  = i * (w - m) - span * 128;
            hi  = lo + w;
            lm  = (i == 0) ? lo : lo + m;
            rm  = (i == n - 1) ? hi : hi - m;
            tex = (i < TEX_LAYERS) ? longint'(texels[i]) : 64'sd0;
            // Zero outside the band, ramps at the edges, full weight in the core
            if (h < lo || h > hi) begin
                wt = 0;
            end else if (h < lm) begin
                wt = (lm - lo <= 0) ? 64'sd256 : ((h - lo) * 256) / (lm - lo);
            end else if (h > rm) begin
                wt = (hi - rm <= 0) ? 64'sd256 : ((hi - h) * 256) / (hi - rm);
            end else begin
                wt = 256;
            end
            sum += (tex * wt) / 256;
        end
        if (sum > 255) sum = 255;
        return TEX_W'(sum);
    endfunction

    // Track register writes, predict accepted pixels, check results, run the watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_span_q  = SPAN_RST;
            cfg_mix_q   = MIX_RST;
            cfg_lcnt_q  = LCNT_RST;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_HEIGHT_SPAN:  cfg_span_q = cfg_data[SPAN_W-1:0];
                    CFG_MIX_FRACTION: cfg_mix_q  = cfg_data[MIX_W-1:0];
                    CFG_LAYER_COUNT:  cfg_lcnt_q = cfg_data[LCNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                if (pix_typed) begin
                    blend_expected = {blend_expected, pix_result};
                end else begin
                    blend_expected = {blend_expected,
                                      blend_predict(s_height_sample, s_texel_layer0,
                                                    s_texel_layer1, s_texel_layer2,
                                                    s_texel_layer3)};
                end
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (blend_expected.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected result transaction: blended_byte %0d",
                                 m_blended_byte);
                end else if (m_blended_byte !== blend_expected[0]) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("blended_byte mismatch: expected %0d, actual %0d",
                                 blend_expected[0], m_blended_byte);
                    void'(blend_expected.pop_front());
                end else begin
                    void'(blend_expected.pop_front());
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** height_blend_texture_mixer: FAILED **");
                $finish;
            end
        end
    end

    // Sink: stall a random number of cycles before taking each result
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Drive one pixel transaction after a random gap; returns on the falling edge after it
    task automatic send_pixel(input pixel_case_t px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_height_sample <= px.height;
        s_texel_layer0  <= px.t0;
        s_texel_layer1  <= px.t1;
        s_texel_layer2  <= px.t2;
        s_texel_layer3  <= px.t3;
        pix_typed       <= px.typed;
        pix_result      <= px.result;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid, hold until every result is back, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (blend_expected.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Rewrite all registers while idle, plus one write to the unused index
    task automatic configure(input logic [CFG_DATA_W-1:0] span,
                             input logic [CFG_DATA_W-1:0] mix,
                             input logic [CFG_DATA_W-1:0] lcnt);
        settle();
        write_reg(CFG_HEIGHT_SPAN, span);
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        write_reg(CFG_MIX_FRACTION, mix);
        write_reg(CFG_LAYER_COUNT, lcnt);
        cfg_valid <= 1'b0;
        cur_span = span;
        cur_mix  = mix;
        cur_lcnt = lcnt;
    endtask

    // Source: reset, directed table, random phases, final check
    initial begin
        pixel_case_t           px;
        logic [CFG_DATA_W-1:0] ph_span, ph_mix, ph_lcnt;
        int                    span_eff, hv, ph, k;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIR_COUNT; k++) begin
            px = DIR_CASES[k];
            if (px.span != cur_span || px.mix != cur_mix || px.lcnt != cur_lcnt)
                configure(px.span, px.mix, px.lcnt);
            send_pixel(px);
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            // First and last phases sit at the register extremes
            if (ph == 0) begin
                ph_span = 16'd1;
                ph_mix  = 16'd0;
                ph_lcnt = 16'd1;
            end else if (ph == RANDOM_PHASES - 1) begin
                ph_span = 16'hFFFF;
                ph_mix  = 16'hFFFF;
                ph_lcnt = 16'hFFFC;
            end else begin
                case ($urandom_range(0, 2))
                    0:       ph_span = CFG_DATA_W'($urandom_range(1, 64));
                    1:       ph_span = CFG_DATA_W'($urandom);
                    default: ph_span = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                endcase
                ph_mix  = CFG_DATA_W'($urandom);
                ph_lcnt = CFG_DATA_W'($urandom);
            end
            configure(ph_span, ph_mix, ph_lcnt);
            no_idle  = (ph == 2 || ph == 5);
            span_eff = (ph_span == '0) ? 1 : int'(ph_span);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                px = '0;
                // Mostly heights across the banded range, sometimes anywhere
                if ($urandom_range(0, 3) == 0) begin
                    px.height = HEIGHT_W'($urandom);
                end else begin
                    hv = int'($urandom_range(0, span_eff + 8)) - (span_eff + 8) / 2;
                    if (hv > 32767) hv = 32767;
                    if (hv < -32768) hv = -32768;
                    px.height = HEIGHT_W'(hv);
                end
                px.t0 = TEX_W'($urandom);
                px.t1 = TEX_W'($urandom);
                px.t2 = TEX_W'($urandom);
                px.t3 = TEX_W'($urandom);
                send_pixel(px);
            end
        end
        no_idle = 1'b0;

        settle();
        if (fault_count == 0 && blend_expected.size() == 0) begin
            $display("** height_blend_texture_mixer: PASSED **");
        end else begin
            $display("** height_blend_texture_mixer: FAILED **");
        end
        $finish;
    end

endmodule
